FILE: rtl/core/radix_digit_string_encoder_macros.svh
// Assertion macros shared by the radix digit string encoder RTL.
`ifndef RADIX_DIGIT_STRING_ENCODER_MACROS_SVH
`define RADIX_DIGIT_STRING_ENCODER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RDSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RDSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define RDSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rdse_pkg.sv
// Types, constants and the digit-to-character mapping of the radix encoder.
package rdse_pkg;

  // Input word width and radix register width
  localparam int unsigned ValueW = 63;
  localparam int unsigned RadixW = 5;
  localparam int unsigned SymW   = 7;

  // Radix limits and reset value
  localparam logic [RadixW-1:0] RadixMin   = 5'd2;
  localparam logic [RadixW-1:0] RadixMax   = 5'd20;
  localparam logic [RadixW-1:0] RadixReset = 5'd10;

  // First characters of the two digit ranges
  localparam logic [SymW-1:0] SymZero = 7'd48;
  localparam logic [SymW-1:0] SymLowA = 7'd97;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_LOAD = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  // Map a remainder to its character: low half to digits, upper half to letters
  function automatic logic [SymW-1:0] sym_of(input logic [RadixW-1:0] rem,
                                             input logic [RadixW-1:0] radix);
    logic [RadixW-1:0] half;
    logic [SymW-1:0]   res;
    half = radix >> 1;
    if (rem < half) begin
      res = SymZero + {2'b00, rem};
    end else begin
      res = SymLowA + {2'b00, rem - half};
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/rdse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rdse_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/radix_digit_string_encoder.sv
// Top level of the radix digit string encoder: serial divider, digit store, output stage.
//
// Converts a 63-bit unsigned word into its digit characters in a radix from
// 2 to 20, most significant character first, one output word per character.
// Input channel: in_valid_i / in_stall_o with value_i; a word is taken when
// valid is high and stall is low. Output channel: out_valid_o / out_stall_i
// with symbol_o and last_symbol_o; last_symbol_o marks the final character.
// Configuration channel: cfg_valid_i / cfg_ready_o with cfg_radix_i; values
// outside 2..20 are dropped. Write only while the encoder is idle.
// Timing: a shared restoring divider produces one quotient bit per cycle,
// and all digits are divided out first; each character then passes through
// the digit store read (ST_RD), the output register load (ST_LOAD) and
// the emit state (ST_EMIT), where it waits while the output is stalled.
// A zero input produces no output words and leaves the sequencer idle.
// in_stall_o is high from acceptance until the last character is taken.
// A stalled output word holds its value; the sequencer waits on it.
// Reset returns the sequencer to idle, clears the digit count and sets
// the radix to 10. The digit store needs no clearing.
`include "radix_digit_string_encoder_macros.svh"

module radix_digit_string_encoder
  import rdse_pkg::*;
#(
  parameter int unsigned DIGIT_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ValueW-1:0] value_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SymW-1:0]   symbol_o,
  output logic              last_symbol_o,
  // configuration channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [RadixW-1:0] cfg_radix_i
);

  localparam int unsigned AddrW = $clog2(DIGIT_DEPTH);
  localparam int unsigned CntW  = $clog2(DIGIT_DEPTH + 1);
  localparam int unsigned BitW  = $clog2(ValueW);
  localparam logic [BitW-1:0] LastBit  = BitW'(ValueW - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DIGIT_DEPTH);

  state_e              state_q, state_d;
  logic [RadixW-1:0]   radix_q;
  logic [ValueW-1:0]   quot_q, quot_d;
  logic [RadixW-1:0]   rem_q, rem_d;
  logic [BitW-1:0]     bit_q, bit_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [AddrW-1:0]    idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  logic [SymW-1:0]     sym_q, sym_d;
  logic                last_q, last_d;

  logic [RadixW:0]     trial;
  logic                take;
  logic [RadixW-1:0]   rem_step;
  logic [ValueW-1:0]   quot_step;
  logic                ram_we;
  logic [RadixW-1:0]   ram_rdata;
  logic [CntW-1:0]     count_m1;
  logic                in_take;

  // Divider step: shift in the next dividend bit, subtract the radix if it fits
  assign trial     = {rem_q, quot_q[ValueW-1]};
  assign take      = (trial >= {1'b0, radix_q});
  assign rem_step  = take ? RadixW'(trial - {1'b0, radix_q}) : trial[RadixW-1:0];
  assign quot_step = {quot_q[ValueW-2:0], take};

  // Keep the remainder once the last quotient bit is known, while room remains
  assign ram_we   = (state_q == ST_DIV) && (bit_q == LastBit) && (count_q < DepthCnt);
  // Address of the most significant kept digit once this digit is stored
  assign count_m1 = ram_we ? count_q : (count_q - CntW'(1));

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    sym_d       = sym_q;
    last_d      = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          quot_d  = value_i;
          rem_d   = '0;
          bit_d   = '0;
          count_d = '0;
          if (value_i != '0) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        quot_d = quot_step;
        rem_d  = rem_step;
        bit_d  = bit_q + BitW'(1);
        if (bit_q == LastBit) begin
          rem_d = '0;
          bit_d = '0;
          if (ram_we) begin
            count_d = count_q + CntW'(1);
          end
          if (quot_step == '0) begin
            idx_d   = count_m1[AddrW-1:0];
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        sym_d       = sym_of(ram_rdata, radix_q);
        last_d      = (idx_q == '0);
        out_valid_d = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - AddrW'(1);
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      quot_q      <= '0;
      radix_q     <= RadixReset;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
      quot_q      <= quot_d;
      if (cfg_valid_i && cfg_ready_o &&
          (cfg_radix_i >= RadixMin) && (cfg_radix_i <= RadixMax)) begin
        radix_q <= cfg_radix_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    idx_q  <= idx_d;
    sym_q  <= sym_d;
    last_q <= last_d;
  end

  // Digit store, least significant digit at address zero
  rdse_ram #(
    .WIDTH(RadixW),
    .DEPTH(DIGIT_DEPTH)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(rem_step),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign symbol_o      = sym_q;
  assign last_symbol_o = last_q;

  `RDSE_ASSERT_IMP(a_rem_below_radix, state_q == ST_DIV, rem_q < radix_q,
    "divider remainder reached the radix")
  `RDSE_ASSERT(a_radix_range, (radix_q >= RadixMin) && (radix_q <= RadixMax),
    "radix register out of range")
  `RDSE_ASSERT_IMP(a_valid_in_emit, out_valid_q, state_q == ST_EMIT,
    "output word valid outside the emit state")
  `RDSE_ASSERT_IMP(a_store_room, ram_we, count_q < DepthCnt,
    "digit store written beyond its depth")
  `RDSE_ASSERT_NEXT(a_last_to_idle, out_valid_o && !out_stall_i && last_symbol_o,
    state_q == ST_IDLE, "encoder not idle after the final character")

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the radix digit string encoder.
module tb
  import rdse_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DigitDepth   = 64;
  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned CycleLimit   = 4000000;
  localparam logic [SymW-1:0] CharZero = 7'h30;
  localparam logic [SymW-1:0] CharA    = 7'h61;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            last;
  } char_word_t;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [ValueW-1:0] value_i      = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [SymW-1:0]   symbol_o;
  logic              last_symbol_o;
  logic              cfg_valid_i  = 1'b0;
  logic              cfg_ready_o;
  logic [RadixW-1:0] cfg_radix_i  = '0;

  // Predictor state: current radix and the characters still owed by the block
  logic [RadixW-1:0] radix_now = RadixReset;
  char_word_t        pending_chars[$];
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;
  bit                idle_on = 1'b1;
  bit                hold_req = 1'b0;

  radix_digit_string_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .symbol_o     (symbol_o),
    .last_symbol_o(last_symbol_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_radix_i  (cfg_radix_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Divide the value down, then queue its characters most significant first
  function automatic void expand_digits(input logic [ValueW-1:0] v);
    logic [63:0]       q;
    logic [RadixW-1:0] digs [DigitDepth];
    logic [RadixW-1:0] half;
    int unsigned       n;
    char_word_t        w;
    q = {1'b0, v};
    n = 0;
    half = radix_now >> 1;
    while (q != 0) begin
      if (n < DigitDepth) begin
        digs[n] = RadixW'(q % radix_now);
        n++;
      end
      q = q / radix_now;
    end
    for (int k = int'(n) - 1; k >= 0; k--) begin
      if (digs[k] < half) begin
        w.sym = CharZero + SymW'(digs[k]);
      end else begin
        w.sym = CharA + SymW'(digs[k] - half);
      end
      w.last = (k == 0);
      pending_chars.push_back(w);
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Random value, mostly short bit lengths, some zeros
  function automatic logic [ValueW-1:0] random_value();
    logic [63:0] raw;
    int unsigned bits;
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return '0;
    bits = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 20) : $urandom_range(21, 63);
    raw = raw & ((64'd1 << bits) - 64'd1);
    raw[bits-1] = 1'b1;
    return raw[ValueW-1:0];
  endfunction

  // Offer one word, predict on acceptance, then idle for a random gap
  task automatic send_value(input logic [ValueW-1:0] v);
    int unsigned gap;
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expand_digits(v);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every expected word has come out
  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the radix register; out-of-range values leave it unchanged
  task automatic set_radix(input logic [RadixW-1:0] r);
    cfg_valid_i <= 1'b1;
    cfg_radix_i <= r;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (r >= RadixMin && r <= RadixMax) radix_now = r;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_radix();
    send_value('0);
    send_value(63'd1);
    send_value(63'd9);
    send_value(63'd10);
    send_value(63'd12345);
    send_value('1);
    send_value(63'd1 << 62);
    drain_words();
  endtask

  task automatic test_radix_extremes();
    set_radix(5'd2);
    send_value('1);
    send_value(63'd1);
    send_value('0);
    drain_words();
    set_radix(5'd20);
    send_value('1);
    send_value(63'd19);
    send_value(63'd10);
    send_value(63'd9);
    drain_words();
    // odd radix: letters start at the middle remainder
    set_radix(5'd3);
    send_value(63'd5);
    drain_words();
    set_radix(5'd17);
    send_value(63'd16);
    drain_words();
  endtask

  task automatic test_bad_radix_writes();
    set_radix(5'd7);
    set_radix(5'd0);
    set_radix(5'd1);
    set_radix(5'd21);
    set_radix(5'd31);
    send_value(63'd48);
    drain_words();
  endtask

  // Stall the output for a long stretch while the sender keeps offering
  task automatic test_output_hold();
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_value(63'($urandom_range(1, 999)));
    drain_words();
  endtask

  task automatic test_random_phases();
    logic [RadixW-1:0] r;
    for (int p = 0; p < 7; p++) begin
      if (p == 0) r = 5'd2;
      else if (p == 1) r = 5'd20;
      else r = RadixW'($urandom_range(2, 20));
      if ($urandom_range(0, 2) == 0) set_radix(RadixW'($urandom_range(21, 31)));
      if ($urandom_range(0, 3) == 0) set_radix(RadixW'($urandom_range(0, 1)));
      set_radix(r);
      idle_on = (p != 3);
      for (int i = 0; i < 20; i++) send_value(random_value());
      drain_words();
    end
    idle_on = 1'b1;
  endtask

  // Output stall pattern: random runs, no stall while idle gaps are off, or one long hold when requested
  initial begin : out_stall_gen
    int unsigned r;
    int unsigned n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!idle_on) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        n = (r < 50) ? $urandom_range(1, 20) :
            (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_stall_i <= (r >= 50);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Compare each accepted output word with the oldest expectation
  always @(posedge clk_i) begin
    char_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word sym=%h last=%b", $time, symbol_o, last_symbol_o);
      end else begin
        w = pending_chars.pop_front();
        if (symbol_o !== w.sym) begin
          mismatches++;
          $display("%0t: symbol expected %h actual %h", $time, w.sym, symbol_o);
        end
        if (last_symbol_o !== w.last) begin
          mismatches++;
          $display("%0t: last_symbol expected %b actual %b", $time, w.last, last_symbol_o);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_radix();
    test_radix_extremes();
    test_bad_radix_writes();
    test_output_hold();
    test_random_phases();
    drain_words();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/rdse_pkg.sv
rtl/core/rdse_ram.sv
rtl/core/radix_digit_string_encoder.sv
verif/tb.sv
